// ===== rtl/rud_pkg.sv =====
// Shared widths and pipeline types for the restoring unsigned divider.
`timescale 1ns / 1ps

package rud_pkg;

  localparam int DATA_WIDTH  = 64;
  localparam int FIELD_WIDTH = 64;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] nq;
    logic [DATA_WIDTH-1:0] den;
  } stage_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
  } result_t;

  localparam logic [1:0] BUF_EMPTY = 2'd0;
  localparam logic [1:0] BUF_ONE   = 2'd1;
  localparam logic [1:0] BUF_FULL  = 2'd2;

endpackage

// ===== rtl/rud_cell.sv =====
// One restoring division step with its pipeline register.
`timescale 1ns / 1ps

module rud_cell
  import rud_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   valid_in,
  input  stage_t data_in,
  output logic   valid_out,
  output stage_t data_out
);

  logic                  carry;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  take;
  stage_t                data_next;

  always_comb begin
    carry   = data_in.rem[DATA_WIDTH-1];
    shifted = {data_in.rem[DATA_WIDTH-2:0], data_in.nq[DATA_WIDTH-1]};
    diff    = {1'b0, carry, shifted} - {2'b00, data_in.den};
    take    = ~diff[DATA_WIDTH+1];
    data_next.rem = take ? diff[DATA_WIDTH-1:0] : shifted;
    // dividend bits leave at the top, quotient bits enter at the bottom
    data_next.nq  = {data_in.nq[DATA_WIDTH-2:0], take};
    data_next.den = data_in.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== rtl/rud_outbuf.sv =====
// Two-entry result buffer that decouples the cell chain from the result stall.
`timescale 1ns / 1ps

module rud_outbuf
  import rud_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    res_stall,
  output logic    res_valid,
  output result_t res_data,
  output logic    full
);

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    e0;
  result_t    e1;
  logic       pop;

  assign res_valid = (count != BUF_EMPTY);
  assign pop       = res_valid && !res_stall;
  assign full      = (count == BUF_FULL);
  assign res_data  = e0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= BUF_EMPTY;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push) begin
        e0 <= push_data;
      end else begin
        e0 <= e1;
      end
    end else if (push) begin
      if (count == BUF_EMPTY) begin
        e0 <= push_data;
      end else begin
        e1 <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == BUF_FULL && !pop) |=> (count == BUF_FULL))
    else $error("result buffer lost an entry while stalled");

  a_drain_one: assert property (@(posedge clk) disable iff (rst)
    (count == BUF_ONE && pop && !push) |=> !res_valid)
    else $error("result buffer did not empty after last transaction");

  a_shift_up: assert property (@(posedge clk) disable iff (rst)
    (count == BUF_FULL && pop) |=> (res_data == $past(e1)))
    else $error("second entry not moved to head after transaction");
`endif

endmodule

// ===== rtl/restoring_unsigned_divider.sv =====
// Top level: pipelined restoring unsigned divider.
//
// Operand channel: dividend and divisor with op_valid/op_stall. A
// transaction takes place at a rising edge with op_valid high and op_stall
// low. Result channel: quotient and remainder with res_valid/res_stall.
// The block accepts one division every cycle while op_stall is low. The
// work runs through a chain of DATA_WIDTH identical cells, one quotient
// bit per cell, each a compare-and-subtract followed by a register. A
// result passes through every cell register and is then held in a
// two-entry output buffer; results leave in operand order.
// A zero divisor gives an all-ones quotient and the dividend as remainder.
// While res_stall is high the buffer fills; once it holds two results,
// op_stall rises and the whole chain holds until a result is taken, so no
// result is dropped. op_stall depends only on registered buffer state.
// Reset (synchronous, rst high) clears every valid bit and empties the
// buffer; results in flight are discarded.
`timescale 1ns / 1ps

module restoring_unsigned_divider
  import rud_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   op_valid,
  output logic                   op_stall,
  input  logic [FIELD_WIDTH-1:0] dividend,
  input  logic [FIELD_WIDTH-1:0] divisor,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [FIELD_WIDTH-1:0] quotient,
  output logic [FIELD_WIDTH-1:0] remainder
);

  logic                valid_chain [DATA_WIDTH+1];
  stage_t              data_chain  [DATA_WIDTH+1];
  logic                adv;
  logic                full;
  result_t             last_res;
  result_t             res_data;

  assign adv      = !full;
  assign op_stall = full;

  assign valid_chain[0]    = op_valid;
  assign data_chain[0].rem = '0;
  assign data_chain[0].nq  = dividend[DATA_WIDTH-1:0];
  assign data_chain[0].den = divisor[DATA_WIDTH-1:0];

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    rud_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .valid_in  (valid_chain[i]),
      .data_in   (data_chain[i]),
      .valid_out (valid_chain[i+1]),
      .data_out  (data_chain[i+1])
    );
  end

  assign last_res.quotient  = data_chain[DATA_WIDTH].nq;
  assign last_res.remainder = data_chain[DATA_WIDTH].rem;

  rud_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && valid_chain[DATA_WIDTH]),
    .push_data (last_res),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .full      (full)
  );

  assign quotient  = FIELD_WIDTH'(res_data.quotient);
  assign remainder = FIELD_WIDTH'(res_data.remainder);

endmodule
